>>> hw/rtl/ovle_pkg.sv
// shared constants and types for the ordered value list engine
package ovle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_FRONT  = 3'd0,
        REQ_BACK   = 3'd1,
        REQ_SEARCH = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

>>> hw/rtl/ordered_value_list_engine.sv
// ordered value list engine: entry memory with a scan and shift sequencer
//
//   channel  | ports                     | beat contents (lowest bit first)
//   ---------+---------------------------+-----------------------------------
//   request  | s_tvalid s_tready s_tdata | req_type[2:0], value[34:3], zero pad
//   result   | m_tvalid m_tready m_tdata | status[1:0], count[6:2], zero pad
//
// one request at a time; the entry memory (one read, one write port) sets the pace
// clear, unused codes, full insert: straight to the result; append writes one entry
// front insert moves every entry up by one (one read and one write per moved entry)
// search reads entries in order to the match; remove then moves later entries down
// aresetn clears count and control; entries need no reset as only live ones are read
// a finished result waits in the output register while the next request is taken
module ordered_value_list_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ovle_pkg::S_TDATA_W-1:0] s_tdata,   // req_type, value, pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ovle_pkg::M_TDATA_W-1:0] m_tdata    // status, count, pad
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_WR,
        S_DONE
    } state_t;

    localparam int CW = ovle_pkg::CNT_W;
    localparam int IW = ovle_pkg::IDX_W;

    state_t                               state_reg;
    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        idx_reg;
    ovle_pkg::req_t                       req_reg;
    logic [ovle_pkg::VALUE_W-1:0]         val_reg;
    ovle_pkg::status_t                    status_reg;
    logic                                 m_tvalid_reg;
    logic [ovle_pkg::M_TDATA_W-1:0]       m_tdata_reg;

    logic [ovle_pkg::VALUE_W-1:0]         mem [ovle_pkg::CAPACITY];
    logic [ovle_pkg::VALUE_W-1:0]         rd_data_reg;

    ovle_pkg::req_t                       in_req;
    logic [ovle_pkg::VALUE_W-1:0]         in_val;
    logic                                 in_fire;
    logic                                 full;
    logic [CW-1:0]                        idx_inc;
    logic [CW-1:0]                        idx_dec;
    logic [CW-1:0]                        count_dec;
    logic [CW-1:0]                        rd_addr;
    logic                                 wr_en;
    logic [CW-1:0]                        wr_addr;
    logic [ovle_pkg::VALUE_W-1:0]         wr_data;
    logic                                 out_free;

    assign in_req    = ovle_pkg::req_t'(s_tdata[ovle_pkg::REQ_W-1:0]);
    assign in_val    = s_tdata[ovle_pkg::REQ_W +: ovle_pkg::VALUE_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(ovle_pkg::CAPACITY));
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // read address: scan at idx, move up reads below idx, move down reads above it
    always_comb begin
        unique case (state_reg)
            S_UP_RD: rd_addr = idx_dec;
            S_DN_RD: rd_addr = idx_inc;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_UP_WR, S_DN_WR: begin
                wr_en = 1'b1;
            end
            S_WR: begin
                wr_en   = 1'b1;
                wr_data = val_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[IW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            status_reg   <= ovle_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in S_DONE the output register is loaded below instead
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        req_reg    <= in_req;
                        val_reg    <= in_val;
                        status_reg <= ovle_pkg::ST_OK;
                        idx_reg    <= '0;
                        unique case (in_req)
                            ovle_pkg::REQ_FRONT: begin
                                if (full) begin
                                    status_reg <= ovle_pkg::ST_FULL;
                                    state_reg  <= S_DONE;
                                end else if (count_reg == '0) begin
                                    state_reg <= S_WR;
                                end else begin
                                    idx_reg   <= count_reg;
                                    state_reg <= S_UP_RD;
                                end
                            end
                            ovle_pkg::REQ_BACK: begin
                                if (full) begin
                                    status_reg <= ovle_pkg::ST_FULL;
                                    state_reg  <= S_DONE;
                                end else begin
                                    idx_reg   <= count_reg;
                                    state_reg <= S_WR;
                                end
                            end
                            ovle_pkg::REQ_SEARCH, ovle_pkg::REQ_REMOVE: begin
                                if (count_reg == '0) begin
                                    status_reg <= ovle_pkg::ST_MISS;
                                    state_reg  <= S_DONE;
                                end else begin
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            ovle_pkg::REQ_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (rd_data_reg == val_reg) begin
                        if (req_reg == ovle_pkg::REQ_SEARCH) begin
                            state_reg <= S_DONE;
                        end else if (idx_inc == count_reg) begin
                            // match on the tail entry, nothing to move
                            count_reg <= count_dec;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_DN_RD;
                        end
                    end else if (idx_inc == count_reg) begin
                        status_reg <= ovle_pkg::ST_MISS;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UP_RD: begin
                    state_reg <= S_UP_WR;
                end
                S_UP_WR: begin
                    idx_reg <= idx_dec;
                    if (idx_reg == CW'(1)) begin
                        state_reg <= S_WR;
                    end else begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_DN_RD: begin
                    state_reg <= S_DN_WR;
                end
                S_DN_WR: begin
                    idx_reg <= idx_inc;
                    if (idx_inc == count_dec) begin
                        count_reg <= count_dec;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DN_RD;
                    end
                end
                S_WR: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0,
                                         ovle_pkg::OUT_COUNT_W'(count_reg),
                                         status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ovle_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("request taken while previous one still in work");

    a_full_only_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == ovle_pkg::ST_FULL) |-> full)
        else $error("full status with room left in the list");
`endif

endmodule
